/* rtl/i2cmt_pkg.sv */
// Shared types and constants for the I2C master transfer engine.
package i2cmt_pkg;

    localparam int          QUEUE_DEPTH_DEF = 2;
    localparam logic [15:0] PHASE_TICKS_RST = 16'd4;

    typedef enum logic [0:0] {
        KIND_TICK = 1'b0,
        KIND_PUSH = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic        sda_sample;
        logic [7:0]  byte_value;
        logic        last_byte;
    } item_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_BUSY  = 2'd1,
        STAT_ERROR = 2'd2,
        STAT_NACK  = 2'd3
    } status_t;

    typedef enum logic [19:0] {
        ST_IDLE  = 20'h00001,
        ST_STA1  = 20'h00002,
        ST_STA2  = 20'h00004,
        ST_STA3  = 20'h00008,
        ST_STA4  = 20'h00010,
        ST_WSET  = 20'h00020,
        ST_WHIGH = 20'h00040,
        ST_WLOW  = 20'h00080,
        ST_ASET  = 20'h00100,
        ST_AHIGH = 20'h00200,
        ST_ALOW  = 20'h00400,
        ST_WAIT  = 20'h00800,
        ST_RHIGH = 20'h01000,
        ST_RLOW  = 20'h02000,
        ST_MSET  = 20'h04000,
        ST_MHIGH = 20'h08000,
        ST_MLOW  = 20'h10000,
        ST_P1    = 20'h20000,
        ST_P2    = 20'h40000,
        ST_P3    = 20'h80000
    } seq_state_t;

endpackage

/* rtl/i2c_master_transfer.sv */
// Top level of the single-master I2C transfer engine.
//
//  channel   direction  handshake           payload
//  s_*       in         s_valid / s_ready   operation, sda_sample, byte_value, last_byte
//  m_*       out        m_valid / m_ready   scl_level, sda_release, byte_wanted,
//                                           read_data, read_valid, done_res, status
//  cfg_*     in         cfg_wr_en           cfg_wr_data = phase_ticks
//
// One transaction per clock while the result channel is not stalled; each produces exactly one result.
// A transaction accepted into the input queue waits there until the sequencer takes it,
// and its result is then registered in the result register.
// The sequencer takes one queued transaction per clock whenever the result
// register is empty or being drained; output stalls back up into the queue.
// Reset (aresetn low, synchronous) empties the queue, releases both lines
// high and restores phase_ticks to 4.
module i2c_master_transfer
    import i2cmt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic        s_sda_sample,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_release,
    output logic        m_byte_wanted,
    output logic [7:0]  m_read_data,
    output logic        m_read_valid,
    output logic        m_done_res,
    output logic [1:0]  m_status
);

    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    i2cmt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_sda_sample (s_sda_sample),
        .s_byte_value (s_byte_value),
        .s_last_byte  (s_last_byte),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    i2cmt_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_level   (m_scl_level),
        .m_sda_release (m_sda_release),
        .m_byte_wanted (m_byte_wanted),
        .m_read_data   (m_read_data),
        .m_read_valid  (m_read_valid),
        .m_done_res    (m_done_res),
        .m_status      (m_status)
    );

endmodule

/* rtl/i2cmt_front.sv */
// Input side: accepts transactions, tags them as tick or push, and queues them.
module i2cmt_front
    import i2cmt_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic        s_sda_sample,
    input  logic [7:0]  s_byte_value,
    input  logic        s_last_byte,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push;
    item_t              in_item;

    always_comb begin
        in_item.kind       = s_operation ? KIND_PUSH : KIND_TICK;
        in_item.sda_sample = s_sda_sample;
        in_item.byte_value = s_byte_value;
        in_item.last_byte  = s_last_byte;
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            if (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + 1'b1;
            end
        end
        if (q_pop) begin
            if (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + 1'b1;
            end
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

/* rtl/i2cmt_engine.sv */
// Bus sequencer: runs START, bytes, ACK and STOP phases and registers each result.
module i2cmt_engine
    import i2cmt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_release,
    output logic        m_byte_wanted,
    output logic [7:0]  m_read_data,
    output logic        m_read_valid,
    output logic        m_done_res,
    output logic [1:0]  m_status
);

    seq_state_t  state_reg, state_next;
    logic [15:0] phase_reg, phase_next;
    logic [2:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic        read_mode_reg, read_mode_next;
    logic        final_reg, final_next;
    logic        loaded_reg, loaded_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    status_t     result_reg, result_next;
    logic [15:0] phase_ticks_reg;

    logic        m_valid_reg;
    logic        out_scl_reg, out_sda_reg, out_wanted_reg;
    logic [7:0]  out_data_reg;
    logic        out_rvalid_reg, out_done_reg;
    status_t     out_status_reg;

    logic        advance;
    logic        waiting;
    logic        phase_end;
    logic [15:0] phase_len;
    logic [7:0]  shift_in;
    logic        o_valid, o_done;
    logic [7:0]  o_data;
    status_t     o_status;

    assign advance  = q_valid && (!m_valid_reg || m_ready);
    assign q_pop    = advance;
    assign waiting  = (state_reg == ST_IDLE) || (state_reg == ST_WAIT);
    assign phase_len = (phase_ticks_reg == '0) ? 16'd1 : phase_ticks_reg;
    assign phase_end = !(({1'b0, phase_reg} + 17'd1) < {1'b0, phase_len});
    assign shift_in  = {shift_reg[6:0], q_item.sda_sample};

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        bit_next       = bit_reg;
        shift_next     = shift_reg;
        read_mode_next = read_mode_reg;
        final_next     = final_reg;
        loaded_next    = loaded_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        result_next    = result_reg;
        o_valid        = 1'b0;
        o_data         = '0;
        o_done         = 1'b0;
        o_status       = STAT_OK;

        if (q_item.kind == KIND_PUSH) begin
            if (waiting && !loaded_reg) begin
                shift_next  = q_item.byte_value;
                final_next  = q_item.last_byte;
                loaded_next = 1'b1;
                phase_next  = '0;
                bit_next    = '0;
                if (state_reg == ST_IDLE) begin
                    // SCL keeps its level into the first START phase
                    read_mode_next = q_item.byte_value[0];
                    result_next    = STAT_OK;
                    state_next     = ST_STA1;
                    sda_next       = 1'b1;
                end else if (read_mode_reg) begin
                    state_next = ST_RHIGH;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end else begin
                    state_next = ST_WSET;
                    scl_next   = 1'b0;
                    sda_next   = q_item.byte_value[7];
                end
            end
        end else if (!waiting) begin
            if (!phase_end) begin
                phase_next = phase_reg + 16'd1;
            end else begin
                phase_next = '0;
                case (state_reg)
                    ST_STA1: begin
                        state_next = ST_STA2; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    ST_STA2: begin
                        if (!q_item.sda_sample) begin
                            // bus held low by someone else
                            state_next  = ST_IDLE;
                            o_done      = 1'b1;
                            o_status    = STAT_BUSY;
                            loaded_next = 1'b0;
                            result_next = STAT_OK;
                            bit_next    = '0;
                        end else begin
                            state_next = ST_STA3; scl_next = 1'b1; sda_next = 1'b0;
                        end
                    end
                    ST_STA3: begin
                        state_next = ST_STA4; scl_next = 1'b0; sda_next = 1'b0;
                    end
                    ST_STA4: begin
                        if (q_item.sda_sample) begin
                            // SDA failed to follow the START; leave lines low
                            state_next  = ST_IDLE;
                            o_done      = 1'b1;
                            o_status    = STAT_ERROR;
                            loaded_next = 1'b0;
                            result_next = STAT_OK;
                            bit_next    = '0;
                        end else begin
                            bit_next   = '0;
                            state_next = ST_WSET;
                            scl_next   = 1'b0;
                            sda_next   = shift_reg[7];
                        end
                    end
                    ST_WSET: begin
                        state_next = ST_WHIGH; scl_next = 1'b1;
                    end
                    ST_WHIGH: begin
                        state_next = ST_WLOW; scl_next = 1'b0;
                    end
                    ST_WLOW: begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        scl_next   = 1'b0;
                        if (bit_reg == 3'd7) begin
                            bit_next   = '0;
                            state_next = ST_ASET;
                            sda_next   = 1'b1;
                        end else begin
                            bit_next   = bit_reg + 3'd1;
                            state_next = ST_WSET;
                            sda_next   = shift_reg[6];
                        end
                    end
                    ST_ASET: begin
                        state_next = ST_AHIGH; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    ST_AHIGH: begin
                        result_next = q_item.sda_sample ? STAT_NACK : STAT_OK;
                        state_next  = ST_ALOW; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    ST_ALOW: begin
                        loaded_next = 1'b0;
                        scl_next    = 1'b0;
                        if (result_reg != STAT_OK || final_reg) begin
                            state_next = ST_P1; sda_next = 1'b0;
                        end else begin
                            state_next = ST_WAIT; sda_next = 1'b1;
                        end
                    end
                    ST_RHIGH: begin
                        shift_next = shift_in;
                        if (bit_reg == 3'd7) begin
                            o_valid = 1'b1;
                            o_data  = shift_in;
                        end
                        state_next = ST_RLOW; scl_next = 1'b0; sda_next = 1'b1;
                    end
                    ST_RLOW: begin
                        if (bit_reg == 3'd7) begin
                            // ACK each byte, NACK the final one
                            bit_next   = '0;
                            state_next = ST_MSET;
                            scl_next   = 1'b0;
                            sda_next   = final_reg;
                        end else begin
                            bit_next   = bit_reg + 3'd1;
                            state_next = ST_RHIGH;
                            scl_next   = 1'b1;
                            sda_next   = 1'b1;
                        end
                    end
                    ST_MSET: begin
                        state_next = ST_MHIGH; scl_next = 1'b1;
                    end
                    ST_MHIGH: begin
                        state_next = ST_MLOW; scl_next = 1'b0;
                    end
                    ST_MLOW: begin
                        loaded_next = 1'b0;
                        scl_next    = 1'b0;
                        if (final_reg) begin
                            state_next = ST_P1; sda_next = 1'b0;
                        end else begin
                            state_next = ST_WAIT; sda_next = 1'b1;
                        end
                    end
                    ST_P1: begin
                        state_next = ST_P2; scl_next = 1'b1; sda_next = 1'b0;
                    end
                    ST_P2: begin
                        state_next = ST_P3; scl_next = 1'b1; sda_next = 1'b1;
                    end
                    ST_P3: begin
                        state_next  = ST_IDLE;
                        o_done      = 1'b1;
                        o_status    = result_reg;
                        loaded_next = 1'b0;
                        result_next = STAT_OK;
                        bit_next    = '0;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            read_mode_reg <= 1'b0;
            final_reg     <= 1'b0;
            loaded_reg    <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            result_reg    <= STAT_OK;
            m_valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                phase_reg     <= phase_next;
                bit_reg       <= bit_next;
                shift_reg     <= shift_next;
                read_mode_reg <= read_mode_next;
                final_reg     <= final_next;
                loaded_reg    <= loaded_next;
                scl_reg       <= scl_next;
                sda_reg       <= sda_next;
                result_reg    <= result_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (cfg_wr_en) begin
            phase_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_scl_reg    <= scl_next;
            out_sda_reg    <= sda_next;
            out_wanted_reg <= ((state_next == ST_IDLE) || (state_next == ST_WAIT))
                              && !loaded_next;
            out_data_reg   <= o_data;
            out_rvalid_reg <= o_valid;
            out_done_reg   <= o_done;
            out_status_reg <= o_status;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_scl_level   = out_scl_reg;
    assign m_sda_release = out_sda_reg;
    assign m_byte_wanted = out_wanted_reg;
    assign m_read_data   = out_data_reg;
    assign m_read_valid  = out_rvalid_reg;
    assign m_done_res    = out_done_reg;
    assign m_status      = out_status_reg;

    // a loaded byte always moves the sequencer off the waiting states
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) || (state_reg == ST_WAIT)) |-> !loaded_reg)
        else $error("byte loaded while sequencer waits");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_done_reg) |-> out_wanted_reg)
        else $error("finished transfer does not ask for a byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_status_reg != STAT_OK) |-> out_done_reg)
        else $error("failure status without transfer end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_rvalid_reg) |-> (!out_done_reg && !out_scl_reg))
        else $error("read byte reported outside the low SCL phase");

endmodule

/* test/i2c_master_transfer_tb.sv */
// Self-checking testbench for the I2C master transfer engine: random transfers vs. a predictor.
module i2c_master_transfer_tb;
    import i2cmt_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        seq_state_t  seq;
        logic [15:0] phase_cnt;
        logic [2:0]  bit_idx;
        logic [7:0]  shreg;
        logic        rd_mode;
        logic        final_pend;
        logic        loaded;
        logic        scl;
        logic        sda;
        status_t     code;
        logic [15:0] ticks;
    } engine_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       byte_wanted;
        logic [7:0] read_data;
        logic       read_valid;
        logic       done_res;
        status_t    status;
    } bus_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = PHASE_TICKS_RST;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = 1'b0;
    logic        s_sda_sample = 1'b0;
    logic [7:0]  s_byte_value = 8'h00;
    logic        s_last_byte = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_scl_level;
    logic        m_sda_release;
    logic        m_byte_wanted;
    logic [7:0]  m_read_data;
    logic        m_read_valid;
    logic        m_done_res;
    logic [1:0]  m_status;

    item_t       bus_item_q[$];
    bus_result_t bus_outputs_q[$];
    item_t       on_bus;
    engine_t     pred_engine;
    engine_t     gen_engine;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          data_left = 0;

    i2c_master_transfer DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_sda_sample  (s_sda_sample),
        .s_byte_value  (s_byte_value),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_level   (m_scl_level),
        .m_sda_release (m_sda_release),
        .m_byte_wanted (m_byte_wanted),
        .m_read_data   (m_read_data),
        .m_read_valid  (m_read_valid),
        .m_done_res    (m_done_res),
        .m_status      (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic engine_t engine_reset();
        engine_t e;
        e.seq        = ST_IDLE;
        e.phase_cnt  = '0;
        e.bit_idx    = '0;
        e.shreg      = '0;
        e.rd_mode    = 1'b0;
        e.final_pend = 1'b0;
        e.loaded     = 1'b0;
        e.scl        = 1'b1;
        e.sda        = 1'b1;
        e.code       = STAT_OK;
        e.ticks      = PHASE_TICKS_RST;
        return e;
    endfunction

    function automatic void enter_phase(inout engine_t e, input seq_state_t s,
                                        input logic scl, input logic sda);
        e.seq = s;
        e.scl = scl;
        e.sda = sda;
    endfunction

    function automatic void close_transfer(inout engine_t e, inout bus_result_t r,
                                           input status_t s);
        e.seq       = ST_IDLE;
        r.done_res  = 1'b1;
        r.status    = s;
        e.loaded    = 1'b0;
        e.code      = STAT_OK;
        e.bit_idx   = '0;
    endfunction

    // One bus tick or byte push through the engine; returns the line levels and flags after it.
    function automatic bus_result_t advance_engine(inout engine_t e, input item_t it);
        bus_result_t r;
        logic        waiting;
        logic [15:0] span;
        r.scl_level   = 1'b0;
        r.sda_release = 1'b0;
        r.byte_wanted = 1'b0;
        r.read_data   = 8'h00;
        r.read_valid  = 1'b0;
        r.done_res    = 1'b0;
        r.status      = STAT_OK;
        waiting = (e.seq == ST_IDLE) || (e.seq == ST_WAIT);
        if (it.kind == KIND_PUSH) begin
            if (waiting && !e.loaded) begin
                e.shreg      = it.byte_value;
                e.final_pend = it.last_byte;
                e.loaded     = 1'b1;
                e.phase_cnt  = '0;
                e.bit_idx    = '0;
                if (e.seq == ST_IDLE) begin
                    // START keeps SCL where it was, so a start after a bus error begins low
                    e.rd_mode = it.byte_value[0];
                    e.code    = STAT_OK;
                    enter_phase(e, ST_STA1, e.scl, 1'b1);
                end else if (e.rd_mode) begin
                    enter_phase(e, ST_RHIGH, 1'b1, 1'b1);
                end else begin
                    enter_phase(e, ST_WSET, 1'b0, it.byte_value[7]);
                end
            end
        end else if (!waiting) begin
            span = (e.ticks == 16'd0) ? 16'd1 : e.ticks;
            if ({1'b0, e.phase_cnt} + 17'd1 < {1'b0, span}) begin
                e.phase_cnt = e.phase_cnt + 16'd1;
            end else begin
                e.phase_cnt = '0;
                case (e.seq)
                    ST_STA1: enter_phase(e, ST_STA2, 1'b1, 1'b1);
                    ST_STA2: begin
                        if (!it.sda_sample) close_transfer(e, r, STAT_BUSY);
                        else enter_phase(e, ST_STA3, 1'b1, 1'b0);
                    end
                    ST_STA3: enter_phase(e, ST_STA4, 1'b0, 1'b0);
                    ST_STA4: begin
                        if (it.sda_sample) begin
                            close_transfer(e, r, STAT_ERROR);
                        end else begin
                            e.bit_idx = '0;
                            enter_phase(e, ST_WSET, 1'b0, e.shreg[7]);
                        end
                    end
                    ST_WSET:  enter_phase(e, ST_WHIGH, 1'b1, e.sda);
                    ST_WHIGH: enter_phase(e, ST_WLOW, 1'b0, e.sda);
                    ST_WLOW: begin
                        e.shreg = {e.shreg[6:0], 1'b0};
                        if (e.bit_idx == 3'd7) begin
                            e.bit_idx = '0;
                            enter_phase(e, ST_ASET, 1'b0, 1'b1);
                        end else begin
                            e.bit_idx = e.bit_idx + 3'd1;
                            enter_phase(e, ST_WSET, 1'b0, e.shreg[7]);
                        end
                    end
                    ST_ASET: enter_phase(e, ST_AHIGH, 1'b1, 1'b1);
                    ST_AHIGH: begin
                        e.code = it.sda_sample ? STAT_NACK : STAT_OK;
                        enter_phase(e, ST_ALOW, 1'b0, 1'b1);
                    end
                    ST_ALOW: begin
                        e.loaded = 1'b0;
                        if (e.code != STAT_OK || e.final_pend)
                            enter_phase(e, ST_P1, 1'b0, 1'b0);
                        else
                            enter_phase(e, ST_WAIT, 1'b0, 1'b1);
                    end
                    ST_RHIGH: begin
                        e.shreg = {e.shreg[6:0], it.sda_sample};
                        if (e.bit_idx == 3'd7) begin
                            r.read_valid = 1'b1;
                            r.read_data  = e.shreg;
                        end
                        enter_phase(e, ST_RLOW, 1'b0, 1'b1);
                    end
                    ST_RLOW: begin
                        // NACK the final read byte by leaving SDA released
                        if (e.bit_idx == 3'd7) begin
                            e.bit_idx = '0;
                            enter_phase(e, ST_MSET, 1'b0, e.final_pend);
                        end else begin
                            e.bit_idx = e.bit_idx + 3'd1;
                            enter_phase(e, ST_RHIGH, 1'b1, 1'b1);
                        end
                    end
                    ST_MSET:  enter_phase(e, ST_MHIGH, 1'b1, e.sda);
                    ST_MHIGH: enter_phase(e, ST_MLOW, 1'b0, e.sda);
                    ST_MLOW: begin
                        e.loaded = 1'b0;
                        if (e.final_pend) enter_phase(e, ST_P1, 1'b0, 1'b0);
                        else enter_phase(e, ST_WAIT, 1'b0, 1'b1);
                    end
                    ST_P1: enter_phase(e, ST_P2, 1'b1, 1'b0);
                    ST_P2: enter_phase(e, ST_P3, 1'b1, 1'b1);
                    ST_P3: close_transfer(e, r, e.code);
                    default: e.seq = ST_IDLE;
                endcase
            end
        end
        r.scl_level   = e.scl;
        r.sda_release = e.sda;
        r.byte_wanted = ((e.seq == ST_IDLE) || (e.seq == ST_WAIT)) && !e.loaded;
        return r;
    endfunction

    // Target behavior on SDA: bus mostly free, rare bus errors, ACK most bytes.
    function automatic logic target_sda(input seq_state_t s);
        case (s)
            ST_STA2:  return $urandom_range(99) < 92;
            ST_STA4:  return $urandom_range(99) < 8;
            ST_AHIGH: return $urandom_range(99) < 15;
            default:  return 1'($urandom_range(1));
        endcase
    endfunction

    task automatic queue_item(input item_kind_t kind, input logic sda, input logic [7:0] val,
                              input logic last);
        item_t       it;
        bus_result_t unused;
        it.kind       = kind;
        it.sda_sample = sda;
        it.byte_value = val;
        it.last_byte  = last;
        bus_item_q.push_back(it);
        unused = advance_engine(gen_engine, it);
    endtask

    task automatic queue_random_item();
        logic wanted;
        logic last;
        int   r;
        wanted = ((gen_engine.seq == ST_IDLE) || (gen_engine.seq == ST_WAIT))
                 && !gen_engine.loaded;
        if ($urandom_range(99) < 4) begin
            queue_item(item_kind_t'(1'($urandom_range(1))), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
        end else if (!wanted) begin
            // mostly ticks; an occasional push while busy must be dropped
            queue_item(($urandom_range(99) < 5) ? KIND_PUSH : KIND_TICK,
                       target_sda(gen_engine.seq), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        end else if ($urandom_range(99) < 15) begin
            queue_item(KIND_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        end else begin
            if (gen_engine.seq == ST_IDLE) begin
                r = $urandom_range(99);
                data_left = (r < 30) ? 0 :
                            (r < 80) ? $urandom_range(2, 1) : $urandom_range(5, 3);
                last = (data_left == 0);
            end else begin
                last = (data_left <= 1);
                if (data_left != 0) data_left--;
            end
            if ($urandom_range(99) < 5) last = ~last;
            queue_item(KIND_PUSH, 1'($urandom_range(1)), 8'($urandom_range(255)), last);
        end
    endtask

    // Run the bus back to idle so the next register write lands between transfers.
    task automatic settle_engine();
        while (gen_engine.seq != ST_IDLE) begin
            if (gen_engine.seq == ST_WAIT)
                queue_item(KIND_PUSH, 1'b0, 8'($urandom_range(255)), 1'b1);
            else
                queue_item(KIND_TICK, target_sda(gen_engine.seq), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        while (bus_item_q.size() != 0 || s_valid || bus_outputs_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_ticks(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        pred_engine.ticks = value;
        gen_engine.ticks  = value;
    endtask

    task automatic run_phase(input logic [15:0] ticks, input int send_pct, input int recv_pct,
                             input int count, input bit pause_midway);
        write_ticks(ticks);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count / 2) queue_random_item();
        // hold the sender until every outstanding transaction has come back
        if (pause_midway) wait_drained();
        repeat (count - count / 2) queue_random_item();
        settle_engine();
        wait_drained();
    endtask

    task automatic note_mismatch(input bus_result_t want, input bus_result_t got);
        if (mismatches < 10) begin
            $display("mismatch on result %0d: expected scl=%b sda=%b wanted=%b data=%02h",
                     results_seen, want.scl_level, want.sda_release, want.byte_wanted,
                     want.read_data, " rv=%b done=%b st=%0d", want.read_valid,
                     want.done_res, want.status);
            $display("    got scl=%b sda=%b wanted=%b data=%02h rv=%b done=%b st=%0d",
                     got.scl_level, got.sda_release, got.byte_wanted, got.read_data,
                     got.read_valid, got.done_res, got.status);
        end
        mismatches++;
    endtask

    // Driver: predict each accepted transaction, then present the next queued one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                bus_outputs_q.push_back(advance_engine(pred_engine, on_bus));
            if (!s_valid || s_ready) begin
                if (bus_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = bus_item_q.pop_front();
                    s_valid      <= 1'b1;
                    s_operation  <= on_bus.kind;
                    s_sda_sample <= on_bus.sda_sample;
                    s_byte_value <= on_bus.byte_value;
                    s_last_byte  <= on_bus.last_byte;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result against the oldest prediction.
    always @(posedge aclk) begin
        bus_result_t got;
        bus_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.scl_level   = m_scl_level;
                got.sda_release = m_sda_release;
                got.byte_wanted = m_byte_wanted;
                got.read_data   = m_read_data;
                got.read_valid  = m_read_valid;
                got.done_res    = m_done_res;
                got.status      = status_t'(m_status);
                if (bus_outputs_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %0d with no transaction pending",
                                 results_seen);
                    mismatches++;
                end else begin
                    want = bus_outputs_q.pop_front();
                    if (got.scl_level !== want.scl_level || got.sda_release !== want.sda_release ||
                        got.byte_wanted !== want.byte_wanted || got.read_data !== want.read_data ||
                        got.read_valid !== want.read_valid || got.done_res !== want.done_res ||
                        got.status !== want.status)
                        note_mismatch(want, got);
                end
                results_seen++;
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", bus_outputs_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        pred_engine = engine_reset();
        gen_engine  = engine_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset value of the phase length, full rate
        repeat (60) queue_random_item();
        settle_engine();
        wait_drained();

        // directed: idle tick, push while busy, bus busy, bus error, start from low lines
        write_ticks(16'd1);
        queue_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        queue_item(KIND_PUSH, 1'b1, 8'hFF, 1'b1);
        queue_item(KIND_PUSH, 1'b0, 8'h00, 1'b0);
        queue_item(KIND_TICK, 1'b1, 8'hFF, 1'b1);
        queue_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        queue_item(KIND_PUSH, 1'b0, 8'h00, 1'b0);
        queue_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        queue_item(KIND_TICK, 1'b1, 8'h00, 1'b0);
        queue_item(KIND_TICK, 1'b0, 8'h00, 1'b0);
        queue_item(KIND_TICK, 1'b1, 8'h00, 1'b0);
        queue_item(KIND_TICK, 1'b1, 8'hFF, 1'b1);
        queue_item(KIND_PUSH, 1'b1, 8'hA4, 1'b1);
        settle_engine();
        wait_drained();

        run_phase(16'd0, 73, 0, 150, 1'b0);
        run_phase(16'd1, 0, 73, 150, 1'b0);
        run_phase(16'd2, 37, 37, 150, 1'b1);

        // longest phase length: a start held in its first phase, then cut short
        // by the shorter length that the next run writes
        write_ticks(16'hFFFF);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_item(KIND_PUSH, 1'b0, 8'h5A, 1'b0);
        repeat (40)
            queue_item(KIND_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
        wait_drained();

        run_phase(16'd3, 0, 0, 150, 1'b0);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
